// ===== hw/rtl/bbcb_pkg.sv =====
// ----------------------------------------------------------------------------
// bbcb_pkg
// Shared constants and types for the foreground bounding box unit.
// ----------------------------------------------------------------------------
package bbcb_pkg;

    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned CNT_W     = $clog2(MAX_DIM);
    localparam int unsigned DIM_W     = 13;
    localparam int unsigned MARGIN_W  = 12;
    localparam int unsigned COLOR_W   = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;
    localparam int unsigned IN_DAT_W  = 24;
    localparam int unsigned OUT_DAT_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_COLOR = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_HEIGHT   = 3'd2,
        CFG_MARGIN_C = 3'd3,
        CFG_MARGIN_R = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] box_top;
        logic [DIM_W-1:0] box_bottom;
        logic [DIM_W-1:0] box_left;
        logic [DIM_W-1:0] box_right;
        logic             found;
    } t_box;

    // frame size limited to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/background_border_crop_box_unit.sv =====
// ----------------------------------------------------------------------------
// background_border_crop_box_unit
// Tracks the bounding box of non-background pixels of a raster frame and
// emits it, widened by the margins, after the last pixel of each frame.
// ----------------------------------------------------------------------------
// a box is registered when the last pixel of a frame leaves the input register
// throughput: one pixel per cycle through the input register and the box update
// the input stalls only when a box is ready while the previous one is still held
// reset clears counters, box state and valids; config returns to its reset values
// ----------------------------------------------------------------------------
module background_border_crop_box_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bbcb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bbcb_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // pixel stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [bbcb_pkg::IN_DAT_W-1:0]  i_s_axis_tdata,  // red, green, blue
    // box stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // box_top, box_bottom, box_left, box_right, found, zero pad
    output logic [bbcb_pkg::OUT_DAT_W-1:0] o_m_axis_tdata
);

    localparam int unsigned CW = bbcb_pkg::CNT_W;
    localparam int unsigned DW = bbcb_pkg::DIM_W;

    logic [bbcb_pkg::COLOR_W-1:0]  r_bg;
    logic [DW-1:0]                 r_width, r_height;
    logic [bbcb_pkg::MARGIN_W-1:0] r_mcol, r_mrow;

    logic                          r_in_valid;
    logic [bbcb_pkg::COLOR_W-1:0]  r_color;

    logic [CW-1:0] r_col, r_row, r_lcol, r_gcol, r_lrow, r_grow;
    logic          r_any;
    logic [CW-1:0] n_col, n_row, n_lcol, n_gcol, n_lrow, n_grow;
    logic          n_any;

    logic          r_out_valid;
    bbcb_pkg::t_box r_box, n_box;

    logic [DW-1:0] w, h, mc, mr;
    logic [DW-1:0] top, bottom, left, right;
    logic          fg, row_end, frame_end, advance;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg     <= '0;
            r_width  <= DW'(64);
            r_height <= DW'(64);
            r_mcol   <= '0;
            r_mrow   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bbcb_pkg::CFG_BG_COLOR: r_bg     <= i_cfg_data[bbcb_pkg::COLOR_W-1:0];
                bbcb_pkg::CFG_WIDTH:    r_width  <= i_cfg_data[DW-1:0];
                bbcb_pkg::CFG_HEIGHT:   r_height <= i_cfg_data[DW-1:0];
                bbcb_pkg::CFG_MARGIN_C: r_mcol   <= i_cfg_data[bbcb_pkg::MARGIN_W-1:0];
                bbcb_pkg::CFG_MARGIN_R: r_mrow   <= i_cfg_data[bbcb_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // frame geometry
    always_comb begin
        w  = bbcb_pkg::clamp_dim(r_width);
        h  = bbcb_pkg::clamp_dim(r_height);
        mc = ({1'b0, r_mcol} >= (w >> 1)) ? '0 : {1'b0, r_mcol};
        mr = ({1'b0, r_mrow} >= (h >> 1)) ? '0 : {1'b0, r_mrow};
        row_end   = {1'b0, r_col} >= (w - DW'(1));
        frame_end = row_end && ({1'b0, r_row} >= (h - DW'(1)));
    end

    assign advance         = r_in_valid && (!frame_end || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // running box update
    always_comb begin
        fg     = r_color != r_bg;
        n_lcol = r_lcol;
        n_gcol = r_gcol;
        n_lrow = r_lrow;
        n_grow = r_grow;
        n_any  = r_any;
        if (fg) begin
            n_any = 1'b1;
            if (!r_any) begin
                n_lcol = r_col;
                n_gcol = r_col;
                n_lrow = r_row;
                n_grow = r_row;
            end else begin
                if (r_col < r_lcol) n_lcol = r_col;
                if (r_col > r_gcol) n_gcol = r_col;
                if (r_row < r_lrow) n_lrow = r_row;
                if (r_row > r_grow) n_grow = r_row;
            end
        end
        if (row_end) begin
            n_col = '0;
            n_row = r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // widened box
    always_comb begin
        if (n_any) begin
            top    = {1'b0, n_lrow};
            bottom = {1'b0, n_grow};
            left   = {1'b0, n_lcol};
            right  = {1'b0, n_gcol};
        end else begin
            top    = '0;
            bottom = h;
            left   = '0;
            right  = w;
        end
        n_box.box_top    = (top > mr) ? top - mr : top;
        n_box.box_bottom = (bottom < h - DW'(1) - mr) ? bottom + mr : bottom;
        n_box.box_left   = (left > mc) ? left - mc : left;
        n_box.box_right  = (right < w - DW'(1) - mc) ? right + mc : right;
        n_box.found      = n_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
            r_lcol <= '0;
            r_gcol <= '0;
            r_lrow <= '0;
            r_grow <= '0;
            r_any  <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance && frame_end) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (frame_end) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_lcol <= '0;
                    r_gcol <= '0;
                    r_lrow <= '0;
                    r_grow <= '0;
                    r_any  <= 1'b0;
                end else begin
                    r_col  <= n_col;
                    r_row  <= n_row;
                    r_lcol <= n_lcol;
                    r_gcol <= n_gcol;
                    r_lrow <= n_lrow;
                    r_grow <= n_grow;
                    r_any  <= n_any;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_color <= {i_s_axis_tdata[23:16], i_s_axis_tdata[15:8], i_s_axis_tdata[7:0]};
        end
        if (advance && frame_end) begin
            r_box <= n_box;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_box.found, r_box.box_right, r_box.box_left,
                              r_box.box_bottom, r_box.box_top};

    // checks
    a_empty_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_box.found) |-> (r_box.box_top == '0 && r_box.box_left == '0))
        else $error("empty box not at origin");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_box.found) |->
        (r_box.box_top <= r_box.box_bottom && r_box.box_left <= r_box.box_right))
        else $error("box edges out of order");

    a_state_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_lcol <= r_gcol && r_lrow <= r_grow))
        else $error("running box out of order");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_lcol == '0 && r_gcol == '0 && r_lrow == '0 && r_grow == '0))
        else $error("running box not cleared");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("box without a pixel");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the foreground bounding box unit: raster frames of
// random pixels over many frame sizes, margins and background colors, every
// box compared field by field against an in-bench model of the box tracker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned MAX_DIM   = bbcb_pkg::MAX_DIM;
    localparam int unsigned CNT_W     = bbcb_pkg::CNT_W;
    localparam int unsigned DIM_W     = bbcb_pkg::DIM_W;
    localparam int unsigned MARGIN_W  = bbcb_pkg::MARGIN_W;
    localparam int unsigned COLOR_W   = bbcb_pkg::COLOR_W;
    localparam int unsigned CFG_DAT_W = bbcb_pkg::CFG_DAT_W;
    localparam int unsigned IN_DAT_W  = bbcb_pkg::IN_DAT_W;
    localparam int unsigned OUT_DAT_W = bbcb_pkg::OUT_DAT_W;

    localparam int QUIET_LIMIT = 3000;
    localparam int ITEM_TARGET = 1700;

    class box_scoreboard;
        logic [COLOR_W-1:0]  bg_color;
        logic [DIM_W-1:0]    width_set;
        logic [DIM_W-1:0]    height_set;
        logic [MARGIN_W-1:0] margin_c;
        logic [MARGIN_W-1:0] margin_r;
        logic [CNT_W-1:0]    col;
        logic [CNT_W-1:0]    row;
        logic [CNT_W-1:0]    col_lo;
        logic [CNT_W-1:0]    col_hi;
        logic [CNT_W-1:0]    row_lo;
        logic [CNT_W-1:0]    row_hi;
        logic                seen;
        bbcb_pkg::t_box      boxes[$];
        int                  errors;
        int                  checked;

        function new();
            bg_color   = '0;
            width_set  = DIM_W'(64);
            height_set = DIM_W'(64);
            margin_c   = '0;
            margin_r   = '0;
            errors     = 0;
            checked    = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            col    = '0;
            row    = '0;
            col_lo = '0;
            col_hi = '0;
            row_lo = '0;
            row_hi = '0;
            seen   = 1'b0;
        endfunction

        function int size_of(logic [DIM_W-1:0] v);
            if (v == '0) begin
                return 1;
            end
            if (v > MAX_DIM) begin
                return MAX_DIM;
            end
            return int'(v);
        endfunction

        function int frame_len();
            return size_of(width_set) * size_of(height_set);
        endfunction

        function int pending();
            return boxes.size();
        endfunction

        function void write_reg(bbcb_pkg::t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                bbcb_pkg::CFG_BG_COLOR: bg_color   = d[COLOR_W-1:0];
                bbcb_pkg::CFG_WIDTH:    width_set  = d[DIM_W-1:0];
                bbcb_pkg::CFG_HEIGHT:   height_set = d[DIM_W-1:0];
                bbcb_pkg::CFG_MARGIN_C: margin_c   = d[MARGIN_W-1:0];
                bbcb_pkg::CFG_MARGIN_R: margin_r   = d[MARGIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [IN_DAT_W-1:0] px);
            int             w;
            int             h;
            int             top;
            int             bottom;
            int             left;
            int             right;
            int             mc;
            int             mr;
            bit             row_end;
            bit             frame_end;
            bbcb_pkg::t_box b;
            w = size_of(width_set);
            h = size_of(height_set);
            if (px != bg_color) begin
                if (!seen) begin
                    col_lo = col;
                    col_hi = col;
                    row_lo = row;
                    row_hi = row;
                    seen   = 1'b1;
                end else begin
                    if (col < col_lo) col_lo = col;
                    if (col > col_hi) col_hi = col;
                    if (row < row_lo) row_lo = row;
                    if (row > row_hi) row_hi = row;
                end
            end
            row_end   = int'(col) >= w - 1;
            frame_end = row_end && int'(row) >= h - 1;
            if (!frame_end) begin
                if (row_end) begin
                    col = '0;
                    row = row + 1'b1;
                end else begin
                    col = col + 1'b1;
                end
                return;
            end
            if (seen) begin
                top    = int'(row_lo);
                bottom = int'(row_hi);
                left   = int'(col_lo);
                right  = int'(col_hi);
            end else begin
                top    = 0;
                left   = 0;
                bottom = h;
                right  = w;
            end
            mc = int'(margin_c);
            mr = int'(margin_r);
            if (mc >= w / 2) mc = 0;
            if (mr >= h / 2) mr = 0;
            if (top > mr) top -= mr;
            if (bottom < h - 1 - mr) bottom += mr;
            if (left > mc) left -= mc;
            if (right < w - 1 - mc) right += mc;
            b.box_top    = DIM_W'(top);
            b.box_bottom = DIM_W'(bottom);
            b.box_left   = DIM_W'(left);
            b.box_right  = DIM_W'(right);
            b.found      = seen;
            boxes.push_back(b);
            restart_frame();
        endfunction

        function void cmp(string name, logic [DIM_W-1:0] expv, logic [DIM_W-1:0] act);
            if (act !== expv) begin
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, expv, act);
                errors++;
            end
        endfunction

        function void check_box(logic [OUT_DAT_W-1:0] d);
            bbcb_pkg::t_box e;
            if (boxes.size() == 0) begin
                $display("%0t: unexpected box, expected none got %h", $time, d);
                errors++;
                return;
            end
            e = boxes.pop_front();
            checked++;
            cmp("box_top", e.box_top, d[12:0]);
            cmp("box_bottom", e.box_bottom, d[25:13]);
            cmp("box_left", e.box_left, d[38:26]);
            cmp("box_right", e.box_right, d[51:39]);
            cmp("found", DIM_W'(e.found), DIM_W'(d[52]));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    bbcb_pkg::t_cfg_idx   cfg_index = bbcb_pkg::CFG_BG_COLOR;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    logic [IN_DAT_W-1:0]  pix_data = '0;
    logic                 box_valid;
    logic                 box_ready = 1'b0;
    logic [OUT_DAT_W-1:0] box_data;

    box_scoreboard sb = new();
    int  quiet = 0;
    int  hold_left = 0;
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;
    int  n_pixels = 0;
    int  n_settings = 0;

    background_border_crop_box_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (pix_valid),
        .o_s_axis_tready (pix_ready),
        .i_s_axis_tdata  (pix_data),
        .o_m_axis_tvalid (box_valid),
        .i_m_axis_tready (box_ready),
        .o_m_axis_tdata  (box_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (pix_valid && pix_ready) sb.note_pixel(pix_data);
            if (box_valid && box_ready) sb.check_box(box_data);
        end
    end

    always @(posedge clk) begin
        if ((cfg_valid && cfg_ready) || (pix_valid && pix_ready) || (box_valid && box_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : watchdog
        wait (quiet >= QUIET_LIMIT);
        $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // box sink, long hold-off counted here
    initial begin : box_sink
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                box_ready <= 1'b0;
                hold_left--;
            end else begin
                box_ready <= !(snk_idle && $urandom_range(0, 99) < 29);
            end
        end
    end

    task automatic put_reg(bbcb_pkg::t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(logic [CFG_DAT_W-1:0] bg, logic [CFG_DAT_W-1:0] w,
                             logic [CFG_DAT_W-1:0] h, logic [CFG_DAT_W-1:0] mc,
                             logic [CFG_DAT_W-1:0] mr);
        put_reg(bbcb_pkg::CFG_BG_COLOR, bg);
        put_reg(bbcb_pkg::CFG_WIDTH, w);
        put_reg(bbcb_pkg::CFG_HEIGHT, h);
        put_reg(bbcb_pkg::CFG_MARGIN_C, mc);
        put_reg(bbcb_pkg::CFG_MARGIN_R, mr);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_pixel(logic [IN_DAT_W-1:0] px);
        if (src_idle && $urandom_range(0, 99) < 29) begin
            pix_valid <= 1'b0;
            do @(posedge clk); while (src_idle && $urandom_range(0, 99) < 29);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        do @(posedge clk); while (!pix_ready);
        n_pixels++;
    endtask

    // stop sending, wait for every box, then let the pipeline settle
    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [IN_DAT_W-1:0] make_pixel(logic [COLOR_W-1:0] bg, int fg_pct);
        if ($urandom_range(0, 99) >= fg_pct) begin
            return bg;
        end
        if ($urandom_range(0, 1) == 1) begin
            return IN_DAT_W'($urandom);
        end
        return bg ^ (24'd1 << $urandom_range(0, 23));
    endfunction

    task automatic run_frames(int frames, int fg_pct);
        repeat (frames * sb.frame_len()) send_pixel(make_pixel(sb.bg_color, fg_pct));
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DAT_W'(1);
            default: return CFG_DAT_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_margin(logic [CFG_DAT_W-1:0] raw);
        int n;
        n = (raw == '0) ? 1 : int'(raw);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CFG_DAT_W'(4095);
            2: return CFG_DAT_W'(n / 2);
            3: return CFG_DAT_W'((n >= 2) ? n / 2 - 1 : 0);
            default: return CFG_DAT_W'($urandom_range(0, n));
        endcase
    endfunction

    initial begin : stimulus
        int                   phase;
        int                   fg_pct;
        logic [CFG_DAT_W-1:0] w;
        logic [CFG_DAT_W-1:0] h;
        logic [CFG_DAT_W-1:0] bg;
        phase = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty frame, then foreground only on the last pixel
        configure(24'h000000, 2, 2, 0, 0);
        repeat (4) send_pixel(24'h000000);
        repeat (3) send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        drain();
        // width zero taken as one, margins too large, one pixel per frame
        configure(24'hFFFFFF, 0, 1, 4095, 4095);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFFFFFE);
        send_pixel(24'h7FFFFF);
        drain();
        // column margin that widens the box
        configure(24'h5A5A5A, 4, 1, 1, 0);
        send_pixel(24'h5A5A5A);
        send_pixel(24'hA5A5A5);
        send_pixel(24'h5A5A5A);
        send_pixel(24'h5A5A5A);
        drain();
        // frame size shrunk in the middle of a frame
        configure(24'h000000, 4, 2, 0, 0);
        send_pixel(24'h000000);
        send_pixel(24'h010203);
        send_pixel(24'h000000);
        send_pixel(24'h000000);
        send_pixel(24'h800000);
        drain();
        configure(24'h000000, 2, 2, 0, 0);
        send_pixel(24'h000000);
        drain();

        while (n_pixels < ITEM_TARGET) begin
            src_idle = !(phase >= 12 && phase < 20);
            snk_idle = src_idle;
            if (phase == 4) begin
                // width above range and height zero, row closed early by a narrow width
                bg = 24'($urandom);
                configure(bg, 8191, 0, CFG_DAT_W'($urandom_range(2047, 2048)), 4095);
                repeat (100) send_pixel(make_pixel(bg, 5));
                drain();
                configure(bg, 2, 0, 0, 0);
                send_pixel(make_pixel(bg, 50));
            end else if (phase == 9) begin
                // every pixel closes a frame; hold the sink so the input backs up
                configure(24'h000000, 1, 1, 0, 0);
                hold_left = 300;
                repeat (40) send_pixel(make_pixel(24'h000000, 50));
                drain();
                repeat (40) send_pixel(make_pixel(24'h000000, 50));
            end else if (phase == 16) begin
                // tallest frame setting, one column, closed early by a short height
                bg = 24'($urandom);
                configure(bg, 0, 4096, 4095, CFG_DAT_W'($urandom_range(2047, 2048)));
                repeat (100) send_pixel(make_pixel(bg, 5));
                drain();
                configure(bg, 0, 2, 0, 0);
                send_pixel(make_pixel(bg, 50));
            end else begin
                case ($urandom_range(0, 3))
                    0: bg = 24'h000000;
                    1: bg = 24'hFFFFFF;
                    default: bg = 24'($urandom);
                endcase
                case ($urandom_range(0, 4))
                    0: fg_pct = 0;
                    1: fg_pct = 2;
                    2: fg_pct = 25;
                    3: fg_pct = 60;
                    default: fg_pct = 100;
                endcase
                w = pick_size();
                h = pick_size();
                configure(bg, w, h, pick_margin(w), pick_margin(h));
                run_frames($urandom_range(1, 4), fg_pct);
                // leave a partial frame for the next setting to pick up
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, sb.frame_len())) send_pixel(make_pixel(bg, fg_pct));
                end
            end
            drain();
            phase++;
        end

        repeat (10) @(posedge clk);
        $display("sent %0d pixels over %0d register settings, checked %0d boxes",
                 n_pixels, n_settings, sb.checked);
        $display("small frames, size limits up to 4096, margin drop, partial frames, backpressure");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
